// File: hdl/orp_pkg.sv
// Package for the orientation pixel remap block: field widths, register
// indexes, orientation codes and the item payload types.
// No dependencies; compile first.
package orp_pkg;

    localparam int MAX_DIM_DEF = 4096;

    localparam int PIX_W     = 32;
    localparam int COORD_W   = 12;
    localparam int INDEX_W   = 24;
    localparam int CFG_W     = 13;
    localparam int CODE_W    = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_CODE  = 2'd2;

    // Orientation codes
    localparam logic [CODE_W-1:0] ORIENT_IDENTITY  = 4'd1;
    localparam logic [CODE_W-1:0] ORIENT_MIRROR_H  = 4'd2;
    localparam logic [CODE_W-1:0] ORIENT_ROT180    = 4'd3;
    localparam logic [CODE_W-1:0] ORIENT_MIRROR_V  = 4'd4;
    localparam logic [CODE_W-1:0] ORIENT_TRANSPOSE = 4'd5;
    localparam logic [CODE_W-1:0] ORIENT_ROT90     = 4'd6;
    localparam logic [CODE_W-1:0] ORIENT_TRANSVERSE = 4'd7;
    localparam logic [CODE_W-1:0] ORIENT_ROT270    = 4'd8;

    localparam logic [CODE_W-1:0] ORIENT_FIRST = ORIENT_IDENTITY;
    localparam logic [CODE_W-1:0] ORIENT_LAST  = ORIENT_ROT270;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic [COORD_W-1:0] dest_col;
        logic [COORD_W-1:0] dest_row;
        logic [INDEX_W-1:0] dest_index;
        logic               frame_last;
        logic               bad_code;
    } t_pix_out;

    // Position status of the pixel at the head of the stream
    typedef struct packed {
        logic row_end;
        logic frame_last;
    } t_pos_flags;

endpackage

// File: hdl/orp_stream_if.sv
// Valid/ready stream channel carrying one item of payload type T.
// Depends on nothing; the payload type is supplied by the user.
interface orp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/orientation_pixel_remap.sv
// Orientation pixel remap, top level. Holds the configuration registers and
// ties the position tracker to the remap pipeline. Depends on orp_pkg,
// orp_stream_if, orp_pos and orp_map.
//
// Source pixels enter in raster order on i_pix, one item per cycle at full
// rate unless o_res stalls; each item leaves on o_res carrying the unchanged
// pixel, its column, row and linear index in the image transformed by the
// orientation code, an end-of-frame flag and an invalid-code flag. Codes 1
// to 4 keep the width (identity, horizontal mirror, 180 degree rotation,
// vertical mirror); codes 5 to 8 swap width and height (transpose, 90 degree
// clockwise, transverse, 270 degree clockwise). Any other code raises
// bad_code and maps as identity. The throughput of one item per clock
// without stalls is set by the two-register pipeline: an input register
// that takes the item with its source position, and a result register
// behind one multiplier and adder that forms the destination index.
// Backpressure on o_res stalls both registers; i_pix.ready stays high while
// either register can still move. Widths and heights of zero read as one,
// values above MAX_DIM read as MAX_DIM, and counters left beyond a shrunken
// frame clamp to its last column or row. Write the configuration only while
// the pipeline is empty; writes do not move the counters, and the counters
// wrap to zero after the last pixel of each frame.
module orientation_pixel_remap #(
    parameter int MAX_DIM = orp_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    orp_stream_if.sink                        i_pix,
    orp_stream_if.source                      o_res,
    input  logic                              i_cfg_we,
    input  logic [orp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [orp_pkg::CFG_W-1:0]         i_cfg_data
);
    import orp_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM+1);
    localparam int XW = (CFG_W > DW) ? CFG_W : DW;

    logic [CFG_W-1:0]  r_frame_width;
    logic [CFG_W-1:0]  r_frame_height;
    logic [CODE_W-1:0] r_orient_code;

    logic [DW-1:0]     eff_w, eff_h;
    logic [CW-1:0]     pos_x, pos_y;
    t_pos_flags        pos_flags;
    logic              in_ready;
    logic              accept;
    t_pix_out          result;

    // Clamp a programmed dimension into 1..MAX_DIM
    function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] d);
        logic [XW-1:0] dx;
        dx = XW'(d);
        if (dx == '0) begin
            return DW'(1);
        end else if (dx > XW'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end
        return DW'(dx);
    endfunction

    // Register writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(1);
            r_frame_height <= CFG_W'(1);
            r_orient_code  <= ORIENT_IDENTITY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_ORIENT_CODE:  r_orient_code  <= CODE_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign eff_w  = eff_dim(r_frame_width);
    assign eff_h  = eff_dim(r_frame_height);

    // Advance the counters on every accepted item
    assign accept      = i_pix.valid && in_ready;
    assign i_pix.ready = in_ready;

    orp_pos #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (accept),
        .i_w     (eff_w),
        .i_h     (eff_h),
        .o_x     (pos_x),
        .o_y     (pos_y),
        .o_flags (pos_flags)
    );

    orp_map #(
        .MAX_DIM (MAX_DIM)
    ) u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (in_ready),
        .i_pixel     (i_pix.data.pixel_in),
        .i_x         (pos_x),
        .i_y         (pos_y),
        .i_flags     (pos_flags),
        .i_w         (eff_w),
        .i_h         (eff_h),
        .i_code      (r_orient_code),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_result    (result)
    );

    assign o_res.data = result;

endmodule

// File: hdl/orp_pos.sv
// Source position tracker: column and row counters, clamped to the frame.
// Depends on orp_pkg.
module orp_pos #(
    parameter int MAX_DIM = orp_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic [$clog2(MAX_DIM+1)-1:0]        i_w,
    input  logic [$clog2(MAX_DIM+1)-1:0]        i_h,
    output logic [$clog2(MAX_DIM)-1:0]          o_x,
    output logic [$clog2(MAX_DIM)-1:0]          o_y,
    output orp_pkg::t_pos_flags                 o_flags
);
    import orp_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM+1);

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] w_last, h_last;

    always_comb begin
        w_last = CW'(i_w - DW'(1));
        h_last = CW'(i_h - DW'(1));
        // clamp if the frame shrank under the counters
        o_x = (DW'(r_col) < i_w) ? r_col : w_last;
        o_y = (DW'(r_row) < i_h) ? r_row : h_last;
        o_flags.row_end    = (o_x == w_last);
        o_flags.frame_last = o_flags.row_end && (o_y == h_last);
    end

    always_comb begin
        if (o_flags.frame_last) begin
            n_col = '0;
            n_row = '0;
        end else if (o_flags.row_end) begin
            n_col = '0;
            n_row = o_y + CW'(1);
        end else begin
            n_col = o_x + CW'(1);
            n_row = o_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && o_flags.frame_last |=> r_col == '0 && r_row == '0)
        else $error("counters did not wrap after last pixel");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !o_flags.row_end |=> r_col == $past(o_x) + CW'(1) && r_row == $past(o_y))
        else $error("column counter did not step");

endmodule

// File: hdl/orp_map.sv
// Two-register remap pipeline: input register holds pixel and position,
// result register holds the mapped coordinates and index. Depends on orp_pkg.
module orp_map #(
    parameter int MAX_DIM = orp_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [orp_pkg::PIX_W-1:0]           i_pixel,
    input  logic [$clog2(MAX_DIM)-1:0]          i_x,
    input  logic [$clog2(MAX_DIM)-1:0]          i_y,
    input  orp_pkg::t_pos_flags                 i_flags,
    input  logic [$clog2(MAX_DIM+1)-1:0]        i_w,
    input  logic [$clog2(MAX_DIM+1)-1:0]        i_h,
    input  logic [orp_pkg::CODE_W-1:0]          i_code,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output orp_pkg::t_pix_out                   o_result
);
    import orp_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM+1);
    localparam int PW = CW + DW;

    logic             r_s1_valid;
    logic             r_s2_valid;
    logic [PIX_W-1:0] r_s1_pixel;
    logic [CW-1:0]    r_s1_x;
    logic [CW-1:0]    r_s1_y;
    logic             r_s1_last;
    t_pix_out         r_res;

    logic             s2_en;
    logic             accept;

    logic [CW-1:0]     rx, ry, dc, dr;
    logic [DW-1:0]     ow;
    logic              bad;
    logic [CODE_W-1:0] code_eff;
    logic [PW-1:0]     prod;
    logic [PW-1:0]     idx_sum;

    // advance the result register when empty or drained
    assign s2_en      = !r_s2_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s2_en;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s2_en) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_en) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel <= i_pixel;
            r_s1_x     <= i_x;
            r_s1_y     <= i_y;
            r_s1_last  <= i_flags.frame_last;
        end
    end

    always_comb begin
        rx       = CW'(i_w - DW'(1)) - r_s1_x;
        ry       = CW'(i_h - DW'(1)) - r_s1_y;
        bad      = (i_code < ORIENT_FIRST) || (i_code > ORIENT_LAST);
        code_eff = bad ? ORIENT_IDENTITY : i_code;
        unique case (code_eff)
            ORIENT_MIRROR_H: begin
                dc = rx;     dr = r_s1_y;
            end
            ORIENT_ROT180: begin
                dc = rx;     dr = ry;
            end
            ORIENT_MIRROR_V: begin
                dc = r_s1_x; dr = ry;
            end
            ORIENT_TRANSPOSE: begin
                dc = r_s1_y; dr = r_s1_x;
            end
            ORIENT_ROT90: begin
                dc = ry;     dr = r_s1_x;
            end
            ORIENT_TRANSVERSE: begin
                dc = ry;     dr = rx;
            end
            ORIENT_ROT270: begin
                dc = r_s1_y; dr = rx;
            end
            default: begin
                dc = r_s1_x; dr = r_s1_y;
            end
        endcase
        // transposing codes swap output width and height
        ow      = (code_eff > ORIENT_MIRROR_V) ? i_h : i_w;
        prod    = PW'(dr) * PW'(ow);
        idx_sum = prod + PW'(dc);
    end

    always_ff @(posedge i_clk) begin
        if (s2_en && r_s1_valid) begin
            r_res.pixel_out  <= r_s1_pixel;
            r_res.dest_col   <= COORD_W'(dc);
            r_res.dest_row   <= COORD_W'(dr);
            r_res.dest_index <= INDEX_W'(idx_sum);
            r_res.frame_last <= r_s1_last;
            r_res.bad_code   <= bad;
        end
    end

    assign o_out_valid = r_s2_valid;
    assign o_result    = r_res;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_en |=> r_s1_valid)
        else $error("stalled item dropped from input register");

    a_s1_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s2_en |=> r_s2_valid)
        else $error("item lost between input and result register");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid && !r_s2_valid |=> !r_s2_valid)
        else $error("result appeared with no item in flight");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for orientation_pixel_remap: streams pixels under many frame
// sizes and orientation codes and checks every result item against a model.
// Depends on orp_pkg, orp_stream_if and the orientation_pixel_remap RTL.
module tb_top;
    import orp_pkg::*;

    localparam int DIM_LIMIT = MAX_DIM_DEF;
    localparam int CFG_MAX   = (1 << CFG_W) - 1;
    localparam int CODE_MAX  = (1 << CODE_W) - 1;
    localparam int RANDOM_ITEMS = 1550;
    localparam int MAX_REPORTS  = 10;

    // Register index past the end of the register list; the block ignores it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Raw codes outside the valid range
    localparam logic [CODE_W-1:0] ORIENT_NONE   = 4'd0;
    localparam logic [CODE_W-1:0] ORIENT_RAWTOP = 4'd15;

    logic i_clk;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    orp_stream_if #(.T(t_pix_in))  pix_if ();
    orp_stream_if #(.T(t_pix_out)) res_if ();

    orientation_pixel_remap #(
        .MAX_DIM (DIM_LIMIT)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Shadow copy of the configuration and the raster position
    logic [CFG_W-1:0]   frame_w_reg = 1;
    logic [CFG_W-1:0]   frame_h_reg = 1;
    logic [CODE_W-1:0]  orient_reg  = ORIENT_IDENTITY;
    logic [COORD_W-1:0] col_pos     = '0;
    logic [COORD_W-1:0] row_pos     = '0;

    t_pix_out remap_q[$];   // destinations still owed by the block
    int       err_count = 0;
    bit       full_rate = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Bound the run well beyond the slowest legal completion.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Zero reads as one, anything above the limit reads as the limit.
    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > DIM_LIMIT)
            return DIM_LIMIT;
        return d;
    endfunction

    // Work out where the next source pixel lands, then advance the raster
    // position exactly as the block does.
    function automatic t_pix_out remap_pixel(input logic [PIX_W-1:0] pix);
        int unsigned w, h, x, y, rx, ry, dc, dr, ow;
        logic bad, row_end, is_last;
        t_pix_out r;
        w  = clamp_dim(frame_w_reg);
        h  = clamp_dim(frame_h_reg);
        // Counters left past a shrunken frame sit on its last column or row
        x  = (col_pos < w) ? col_pos : w - 1;
        y  = (row_pos < h) ? row_pos : h - 1;
        rx = w - 1 - x;
        ry = h - 1 - y;
        bad = (orient_reg < ORIENT_FIRST) || (orient_reg > ORIENT_LAST);
        case (bad ? ORIENT_IDENTITY : orient_reg)
            ORIENT_MIRROR_H: begin
                dc = rx; dr = y;  ow = w;
            end
            ORIENT_ROT180: begin
                dc = rx; dr = ry; ow = w;
            end
            ORIENT_MIRROR_V: begin
                dc = x;  dr = ry; ow = w;
            end
            ORIENT_TRANSPOSE: begin
                dc = y;  dr = x;  ow = h;
            end
            ORIENT_ROT90: begin
                dc = ry; dr = x;  ow = h;
            end
            ORIENT_TRANSVERSE: begin
                dc = ry; dr = rx; ow = h;
            end
            ORIENT_ROT270: begin
                dc = y;  dr = rx; ow = h;
            end
            default: begin
                dc = x;  dr = y;  ow = w;
            end
        endcase
        row_end = (x == w - 1);
        is_last = row_end && (y == h - 1);

        r.pixel_out  = pix;
        r.dest_col   = COORD_W'(dc);
        r.dest_row   = COORD_W'(dr);
        r.dest_index = INDEX_W'(dr * ow + dc);
        r.frame_last = is_last;
        r.bad_code   = bad;

        // Wrap at end of frame, drop to the next row at end of row
        if (is_last) begin
            col_pos = '0;
            row_pos = '0;
        end else if (row_end) begin
            col_pos = '0;
            row_pos = COORD_W'(y + 1);
        end else begin
            col_pos = COORD_W'(x + 1);
            row_pos = COORD_W'(y);
        end
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one; none at all
    // while a full-rate stretch is running.
    function automatic int pick_gap();
        int r;
        if (full_rate)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Hold each pixel on the channel until the block takes it, then log the
    // expected destination. Returns at a falling edge with valid still high,
    // so back-to-back items keep valid asserted.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.valid = 1'b1;
        pix_if.data  = pix;
        @(posedge i_clk);
        while (!pix_if.ready)
            @(posedge i_clk);
        remap_q.push_back(remap_pixel(pix));
        @(negedge i_clk);
    endtask

    // Stop the stream, let the pipeline drain, then write one register.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        pix_if.valid = 1'b0;
        while (remap_q.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  frame_w_reg = val;
            CFG_FRAME_HEIGHT: frame_h_reg = val;
            CFG_ORIENT_CODE:  orient_reg  = CODE_W'(val);
            default: ;
        endcase
    endtask

    // Sink side: stall at random, sampled by the block at the rising edge.
    initial begin
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else begin
                stall_left   = pick_gap();
                res_if.ready = (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Compare every accepted result with the oldest outstanding destination.
    always @(posedge i_clk) begin
        t_pix_out want, got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (remap_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected result pixel=%h col=%0d row=%0d", $realtime,
                             got.pixel_out, got.dest_col, got.dest_row);
            end else begin
                want = remap_q.pop_front();
                if (got.pixel_out !== want.pixel_out || got.dest_col !== want.dest_col ||
                    got.dest_row !== want.dest_row || got.dest_index !== want.dest_index ||
                    got.frame_last !== want.frame_last || got.bad_code !== want.bad_code) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch", $realtime);
                        $display("  exp pixel=%h col=%0d row=%0d index=%0d last=%b bad=%b",
                                 want.pixel_out, want.dest_col, want.dest_row,
                                 want.dest_index, want.frame_last, want.bad_code);
                        $display("  got pixel=%h col=%0d row=%0d index=%0d last=%b bad=%b",
                                 got.pixel_out, got.dest_col, got.dest_row,
                                 got.dest_index, got.frame_last, got.bad_code);
                    end
                end
            end
        end
    end

    // Reset defaults: a 1x1 frame, so every item closes a frame.
    task automatic test_reset_values();
        send_pixel('0);
        send_pixel('1);
    endtask

    // Walk all eight codes over a 3x2 frame, two items per code; the raster
    // position carries over between codes, so each code sees other positions than the one before.
    task automatic test_orient_codes();
        write_reg(CFG_FRAME_WIDTH, 3);
        write_reg(CFG_FRAME_HEIGHT, 2);
        for (int c = ORIENT_FIRST; c <= ORIENT_LAST; c++) begin
            write_reg(CFG_ORIENT_CODE, CFG_W'(c));
            send_pixel($urandom());
            send_pixel($urandom());
        end
    endtask

    // Codes at both ends of the invalid range: flag and map as identity.
    task automatic test_bad_codes();
        write_reg(CFG_ORIENT_CODE, CFG_W'(ORIENT_NONE));
        send_pixel($urandom());
        write_reg(CFG_ORIENT_CODE, CFG_W'(ORIENT_RAWTOP));
        send_pixel($urandom());
    endtask

    // Zero dimensions read as one; oversized ones clamp to the limit, which
    // also drives every coordinate and index bit high.
    task automatic test_dim_extremes();
        write_reg(CFG_ORIENT_CODE, CFG_W'(ORIENT_IDENTITY));
        write_reg(CFG_FRAME_WIDTH, 0);
        write_reg(CFG_FRAME_HEIGHT, 0);
        send_pixel($urandom());
        write_reg(CFG_FRAME_WIDTH, CFG_W'(CFG_MAX));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(CFG_MAX));
        write_reg(CFG_ORIENT_CODE, CFG_W'(ORIENT_ROT180));
        send_pixel($urandom());
        write_reg(CFG_FRAME_WIDTH, CFG_W'(DIM_LIMIT));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(DIM_LIMIT));
        write_reg(CFG_ORIENT_CODE, CFG_W'(ORIENT_ROT90));
        send_pixel($urandom());
    endtask

    // Shrink the frame under a running counter so it clamps to the last
    // column; a write to the unused index must change nothing.
    task automatic test_frame_shrink();
        write_reg(CFG_FRAME_WIDTH, 2);
        write_reg(CFG_FRAME_HEIGHT, 1);
        write_reg(CFG_ORIENT_CODE, CFG_W'(ORIENT_MIRROR_V));
        write_reg(CFG_UNUSED, CFG_W'(CFG_MAX));
        repeat (3) send_pixel($urandom());
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return CFG_W'($urandom_range(1, 10));
        if (r < 92)
            return '0;
        if (r < 96)
            return CFG_W'(DIM_LIMIT);
        return CFG_W'($urandom_range(DIM_LIMIT + 1, CFG_MAX));
    endfunction

    // Random phases: new sizes and code, then mostly complete frames from
    // the current position, otherwise a short burst that may stop mid-frame.
    task automatic test_random_frames(input int n_items);
        int done_items, n, w, h, x, y, fsize;
        logic [CFG_W-1:0] wv, hv;
        done_items = 0;
        while (done_items < n_items) begin
            wv = pick_dim();
            hv = pick_dim();
            write_reg(CFG_FRAME_WIDTH, wv);
            write_reg(CFG_FRAME_HEIGHT, hv);
            if ($urandom_range(0, 4) != 0)
                write_reg(CFG_ORIENT_CODE, CFG_W'($urandom_range(ORIENT_FIRST, ORIENT_LAST)));
            else
                write_reg(CFG_ORIENT_CODE, CFG_W'($urandom_range(0, CODE_MAX)));
            full_rate = ($urandom_range(0, 5) == 0);
            w = clamp_dim(wv);
            h = clamp_dim(hv);
            fsize = w * h;
            if (fsize <= 100 && $urandom_range(0, 6) != 0) begin
                x = (col_pos < w) ? col_pos : w - 1;
                y = (row_pos < h) ? row_pos : h - 1;
                n = fsize - (y * w + x) + fsize * $urandom_range(0, 1);
            end else begin
                n = $urandom_range(1, 24);
            end
            repeat (n) send_pixel($urandom());
            done_items += n;
        end
        full_rate = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_FRAME_WIDTH;
        cfg_data     = '0;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_orient_codes();
        test_bad_codes();
        test_dim_extremes();
        test_frame_shrink();
        test_random_frames(RANDOM_ITEMS);

        // Drain what is still in flight, then allow the pipeline to settle.
        pix_if.valid = 1'b0;
        while (remap_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0 && remap_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: orientation_pixel_remap.f
hdl/orp_pkg.sv
hdl/orp_stream_if.sv
hdl/orp_pos.sv
hdl/orp_map.sv
hdl/orientation_pixel_remap.sv
dv/tb_top.sv
